@@ src/ptbg_pkg.sv @@
// Package for the palette tint, blend and gamma block.
// Holds the word types, the shift count and the per-channel blend function.
// Used by every module of the block; depends on nothing.
package ptbg_pkg;

	localparam int NUM_SHIFTS = 4;
	localparam int NUM_REGS = 4;
	localparam int CFG_IDX_W = 8;
	localparam int GAMMA_DEPTH = 256;

	typedef enum logic {
		FUNC_BLEND = 1'b0,
		FUNC_GAMMA = 1'b1
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] gamma_index;
		logic [7:0] gamma_value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} out_word_t;

	typedef struct packed {
		logic     valid;
		in_word_t word;
	} stage_t;

	// c + floor(s * (t - c) / 256); the result stays between c and t.
	function automatic logic [7:0] blend_channel(input logic [7:0] c, input logic [7:0] t,
			input logic [7:0] s);
		logic signed [8:0]  diff;
		logic signed [17:0] prod;
		diff = $signed({1'b0, t}) - $signed({1'b0, c});
		prod = $signed({1'b0, s}) * diff;
		return c + prod[15:8];
	endfunction

endpackage

@@ src/ptbg_blend_stage.sv @@
// One colour shift of the cascade as a single pipeline stage.
// Depends on ptbg_pkg for the stage type and the blend function.
module ptbg_blend_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          shift_word,
	input  ptbg_pkg::stage_t     prev,
	output logic                 prev_ready,
	output ptbg_pkg::stage_t     next,
	input  logic                 next_ready
);

	logic               valid_s1;
	ptbg_pkg::in_word_t word_s1;
	ptbg_pkg::in_word_t blended;
	logic [7:0]         strength;

	assign strength = shift_word[31:24];
	assign prev_ready = !valid_s1 || next_ready;

	always_comb begin
		blended = prev.word;
		blended.red = ptbg_pkg::blend_channel(prev.word.red, shift_word[23:16], strength);
		blended.green = ptbg_pkg::blend_channel(prev.word.green, shift_word[15:8], strength);
		blended.blue = ptbg_pkg::blend_channel(prev.word.blue, shift_word[7:0], strength);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prev_ready) begin
			valid_s1 <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev.valid) begin
			word_s1 <= blended;
		end
	end

	assign next.valid = valid_s1;
	assign next.word = word_s1;

endmodule

@@ src/ptbg_gamma.sv @@
// Gamma lookup stage and output register of the block.
// Holds one copy of the gamma table per channel and the shared entry valid bits.
// Depends on ptbg_pkg for the word types.
module ptbg_gamma (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptbg_pkg::stage_t     prev,
	output logic                 prev_ready,
	output logic                 valid,
	output ptbg_pkg::out_word_t  data,
	input  logic                 stall
);

	logic [7:0] mem_r [ptbg_pkg::GAMMA_DEPTH];
	logic [7:0] mem_g [ptbg_pkg::GAMMA_DEPTH];
	logic [7:0] mem_b [ptbg_pkg::GAMMA_DEPTH];
	logic [ptbg_pkg::GAMMA_DEPTH-1:0] written_q;

	logic       valid_s1;
	logic [7:0] rd_r_s1, rd_g_s1, rd_b_s1;
	logic [7:0] addr_r_s1, addr_g_s1, addr_b_s1;
	logic       hit_r_s1, hit_g_s1, hit_b_s1;
	logic       take;
	logic       wr_en;
	logic       rd_en;

	assign prev_ready = !valid_s1 || !stall;
	assign take = prev_ready && prev.valid;
	assign wr_en = take && (prev.word.func == ptbg_pkg::FUNC_GAMMA);
	assign rd_en = take && (prev.word.func == ptbg_pkg::FUNC_BLEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			written_q <= '0;
		end else begin
			if (prev_ready) begin
				valid_s1 <= prev.valid && (prev.word.func == ptbg_pkg::FUNC_BLEND);
			end
			if (wr_en) begin
				written_q[prev.word.gamma_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_r[prev.word.gamma_index] <= prev.word.gamma_value;
			mem_g[prev.word.gamma_index] <= prev.word.gamma_value;
			mem_b[prev.word.gamma_index] <= prev.word.gamma_value;
		end
		if (rd_en) begin
			rd_r_s1 <= mem_r[prev.word.red];
			rd_g_s1 <= mem_g[prev.word.green];
			rd_b_s1 <= mem_b[prev.word.blue];
			addr_r_s1 <= prev.word.red;
			addr_g_s1 <= prev.word.green;
			addr_b_s1 <= prev.word.blue;
			hit_r_s1 <= written_q[prev.word.red];
			hit_g_s1 <= written_q[prev.word.green];
			hit_b_s1 <= written_q[prev.word.blue];
		end
	end

	// An entry never written reads as its own index through its valid bit; the table itself has no reset.
	assign data.out_red = hit_r_s1 ? rd_r_s1 : addr_r_s1;
	assign data.out_green = hit_g_s1 ? rd_g_s1 : addr_g_s1;
	assign data.out_blue = hit_b_s1 ? rd_b_s1 : addr_b_s1;
	assign valid = valid_s1;

endmodule

@@ src/palette_tint_blend_gamma.sv @@
// Palette tint, blend and gamma block: a cascade of colour shift stages and a gamma stage.
// Depends on ptbg_pkg, ptbg_blend_stage and ptbg_gamma.
//
// One word is taken per clock while src_stall is low. A colour passes one
// register stage per colour shift, each holding one 8 by 9 bit multiply and
// add per channel, then the gamma table read stage, which is also the output
// register. A gamma write word travels the same stages and updates
// the table as it enters the gamma stage, so it affects exactly the colours
// taken after it and produces no output word. Each stage loads whenever it is
// empty or its successor moves, so empty slots are filled while an output word
// waits under stall; src_stall rises only when every stage is occupied and
// dst_stall is high. The gamma table reads as the identity after reset without
// any clearing pass. Shift registers are written at any time cfg_valid is high
// and cfg_ready is always high; indexes of four and above are ignored.
module palette_tint_blend_gamma (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  ptbg_pkg::in_word_t                src_data,
	output logic                              dst_valid,
	input  logic                              dst_stall,
	output ptbg_pkg::out_word_t               dst_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptbg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [31:0]      shift_q [ptbg_pkg::NUM_REGS];
	ptbg_pkg::stage_t chain [ptbg_pkg::NUM_SHIFTS+1];
	logic             ready [ptbg_pkg::NUM_SHIFTS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptbg_pkg::NUM_REGS; i++) begin
				shift_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < ptbg_pkg::NUM_REGS; i++) begin
				if (cfg_index == ptbg_pkg::CFG_IDX_W'(i)) begin
					shift_q[i] <= cfg_data;
				end
			end
		end
	end

	assign chain[0].valid = src_valid;
	assign chain[0].word = src_data;
	assign src_stall = !ready[0];

	for (genvar g = 0; g < ptbg_pkg::NUM_SHIFTS; g++) begin : g_shift
		ptbg_blend_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_word (shift_q[g]),
			.prev       (chain[g]),
			.prev_ready (ready[g]),
			.next       (chain[g+1]),
			.next_ready (ready[g+1])
		);
	end

	ptbg_gamma u_gamma (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev       (chain[ptbg_pkg::NUM_SHIFTS]),
		.prev_ready (ready[ptbg_pkg::NUM_SHIFTS]),
		.valid      (dst_valid),
		.data       (dst_data),
		.stall      (dst_stall)
	);

endmodule

@@ src/ptbg_checker.sv @@
// Port-level checks for the palette tint, blend and gamma block, bound to its top level.
// Depends on ptbg_pkg for the word types.
module ptbg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_stall,
	input logic                dst_valid,
	input logic                dst_stall,
	input ptbg_pkg::out_word_t dst_data,
	input logic                cfg_valid,
	input logic                cfg_ready
);

	// The input may only be held off when the whole pipeline is blocked by the output.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall)
		else $error("input stalled while output is free");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled output word changed");

	// No word can reach the output in the first cycle after reset.
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !dst_valid)
		else $error("output valid right after reset");

	// Configuration writes are never held off, even while an input word is offered.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && src_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind palette_tint_blend_gamma ptbg_checker u_ptbg_checker (.*);
